// File: design/scf_pkg.sv
`default_nettype none

package scf_pkg;

    localparam int MAX_FRAME = 16;
    localparam int IDX_W     = $clog2(MAX_FRAME);
    localparam int FILL_W    = $clog2(MAX_FRAME + 1);
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] START_CHAR = 8'h61;
    localparam logic [BYTE_W-1:0] END_CHAR   = 8'h2D;

    localparam logic [LEN_W-1:0] SHORT_LEN_RST = 5'd5;
    localparam logic [LEN_W-1:0] LONG_LEN_RST  = 5'd12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_MODE  = 2'd0,
        CFG_SHORT_LEN   = 2'd1,
        CFG_LONG_LEN    = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SHOW
    } bk_state_t;

    // Front -> queue: byte store write and frame push.
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] data;
        logic              push;
        logic [FILL_W-1:0] size;
    } fr_wr_t;

    // Back -> queue: byte fetch and frame pop.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic             pop;
    } bk_rd_t;

    // Queue status toward both sides.
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [FILL_W-1:0] head_size;
    } q_stat_t;

endpackage

`default_nettype wire

// File: design/scf_front.sv
`default_nettype none

module scf_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scf_pkg::LEN_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [scf_pkg::BYTE_W-1:0]     rx_byte,
    input  wire scf_pkg::q_stat_t               stat,
    output scf_pkg::fr_wr_t                     wr
);
    import scf_pkg::*;

    logic              short_mode_reg, short_mode_next;
    logic [LEN_W-1:0]  short_len_reg, short_len_next;
    logic [LEN_W-1:0]  long_len_reg, long_len_next;
    logic [FILL_W-1:0] fill_count_reg, fill_count_next;

    logic [LEN_W-1:0]  sel_len;
    logic [FILL_W-1:0] act_len;
    logic [FILL_W-1:0] fill0;
    logic [FILL_W-1:0] new_fill;
    logic              stored;
    logic              is_start;
    logic              is_end;
    logic              accept;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;
    assign is_start = (rx_byte == START_CHAR);
    assign is_end   = (rx_byte == END_CHAR);

    // Clamp the active length to 1..MAX_FRAME.
    always_comb
    begin
        sel_len = short_mode_reg ? short_len_reg : long_len_reg;
        if (sel_len == '0)
            act_len = FILL_W'(1);
        else if (32'(sel_len) > MAX_FRAME)
            act_len = FILL_W'(MAX_FRAME);
        else
            act_len = FILL_W'(sel_len);
    end

    always_comb
    begin
        fill0    = (fill_count_reg >= act_len) ? '0 : fill_count_reg;
        stored   = 1'b0;
        new_fill = fill0;
        wr       = '0;
        wr.data  = rx_byte;
        if (fill0 == '0)
        begin
            if (is_start)
            begin
                stored   = 1'b1;
                new_fill = FILL_W'(1);
            end
        end
        else if (is_start && (!short_mode_reg || (fill0 + FILL_W'(1)) < act_len))
        begin
            stored   = 1'b1;
            new_fill = FILL_W'(1);
        end
        else
        begin
            stored   = 1'b1;
            wr.idx   = fill0[IDX_W-1:0];
            new_fill = fill0 + FILL_W'(1);
        end
        wr.en   = accept && stored;
        wr.push = wr.en && (new_fill == act_len || is_end);
        wr.size = new_fill;
    end

    always_comb
    begin
        short_mode_next = short_mode_reg;
        short_len_next  = short_len_reg;
        long_len_next   = long_len_reg;
        fill_count_next = fill_count_reg;
        if (accept)
            fill_count_next = (!stored || wr.push) ? '0 : new_fill;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SHORT_MODE:
                begin
                    short_mode_next = cfg_data[0];
                    fill_count_next = '0;
                end
                CFG_SHORT_LEN:
                begin
                    short_len_next  = cfg_data;
                    fill_count_next = '0;
                end
                CFG_LONG_LEN:
                begin
                    long_len_next   = cfg_data;
                    fill_count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_mode_reg <= 1'b0;
            short_len_reg  <= SHORT_LEN_RST;
            long_len_reg   <= LONG_LEN_RST;
            fill_count_reg <= '0;
        end
        else
        begin
            short_mode_reg <= short_mode_next;
            short_len_reg  <= short_len_next;
            long_len_reg   <= long_len_next;
            fill_count_reg <= fill_count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/scf_queue.sv
`default_nettype none

module scf_queue (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire scf_pkg::fr_wr_t             wr,
    input  wire scf_pkg::bk_rd_t             rd,
    output scf_pkg::q_stat_t                 stat,
    output logic [scf_pkg::BYTE_W-1:0]       rd_data
);
    import scf_pkg::*;

    // Two frame slots; the front fills slot wr_ptr while the back drains rd_ptr.
    logic [BYTE_W-1:0] mem [2][MAX_FRAME];
    logic [FILL_W-1:0] size_reg [2];
    logic [BYTE_W-1:0] rd_data_reg;
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign stat.full      = (count_reg == 2'd2);
    assign stat.empty     = (count_reg == 2'd0);
    assign stat.head_size = size_reg[rd_ptr_reg];
    assign rd_data        = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr.push;
        rd_ptr_next = rd_ptr_reg ^ rd.pop;
        count_next  = count_reg;
        if (wr.push && !rd.pop)
            count_next = count_reg + 2'd1;
        else if (!wr.push && rd.pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr_ptr_reg][wr.idx] <= wr.data;
        if (wr.push)
            size_reg[wr_ptr_reg] <= wr.size;
        if (rd.en)
            rd_data_reg <= mem[rd_ptr_reg][rd.idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/scf_back.sv
`default_nettype none

module scf_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire scf_pkg::q_stat_t            stat,
    output scf_pkg::bk_rd_t                  rd,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             frame_end,
    output logic [scf_pkg::LEN_W-1:0]        frame_size
);
    import scf_pkg::*;

    bk_state_t        state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last;
    logic             take;

    assign last       = ((FILL_W'(idx_reg) + FILL_W'(1)) == stat.head_size);
    assign take       = (state_reg == BK_SHOW) && out_ready;
    assign frame_end  = last;
    assign frame_size = LEN_W'(stat.head_size);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!stat.empty)
                    state_next = BK_FETCH;
            end
            BK_FETCH:
                state_next = BK_SHOW;
            BK_SHOW:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        idx_next   = '0;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        rd.en     = (state_reg == BK_FETCH);
        rd.idx    = idx_reg;
        rd.pop    = take && last;
        out_valid = (state_reg == BK_SHOW);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

// File: design/serial_command_framer.sv
`default_nettype none

// Channel   Handshake              Payload
// -------   --------------------   ---------------------------------------
// input     in_valid / in_ready    rx_byte
// output    out_valid / out_ready  frame_byte, frame_end, frame_size
// config    cfg_we                 cfg_index, cfg_data
//
// An input beat is taken whenever a frame slot is free; the front stalls
// only while both frame slots hold finished frames not yet drained.
// Each output beat passes a fetch state (read from the frame store), then a
// show state, set by the registered read port of the two-slot frame store.
// Reset clears the configuration to long mode with lengths 5 and 12, empties
// the queue and drops any partial frame. A stalled output beat holds its
// payload in the read register until taken.

module serial_command_framer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scf_pkg::LEN_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [scf_pkg::BYTE_W-1:0]     rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [scf_pkg::BYTE_W-1:0]          frame_byte,
    output logic                                frame_end,
    output logic [scf_pkg::LEN_W-1:0]           frame_size
);
    import scf_pkg::*;

    fr_wr_t  wr;
    bk_rd_t  rd;
    q_stat_t stat;

    // Front: collect bytes, apply start/restart/end rules, push whole frames.
    scf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .stat      (stat),
        .wr        (wr)
    );

    // Queue: two frame slots plus their sizes, so front and back stall apart.
    scf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd      (rd),
        .stat    (stat),
        .rd_data (frame_byte)
    );

    // Back: drain the head frame one beat at a time, mark the last byte.
    scf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .stat       (stat),
        .rd         (rd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_end  (frame_end),
        .frame_size (frame_size)
    );

    // A shown beat always belongs to a queued frame.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !stat.empty)
        else $error("output beat without a queued frame");

    // Queue count never reads as both full and empty.
    assert property (@(posedge clk) disable iff (!rst_n) !(stat.full && stat.empty))
        else $error("queue status inconsistent");

    // Emitted frame size stays within 1..MAX_FRAME.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (frame_size != '0 && 32'(frame_size) <= MAX_FRAME))
        else $error("frame size out of range");

    // A frame push only happens while a slot is free.
    assert property (@(posedge clk) disable iff (!rst_n) wr.push |-> !stat.full)
        else $error("frame pushed into a full queue");

endmodule

`default_nettype wire

// File: tb/frame_checker.sv
`timescale 1ns / 1ps

module frame_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [scf_pkg::LEN_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    input  wire logic                           in_ready,
    input  wire logic [scf_pkg::BYTE_W-1:0]     rx_byte,
    input  wire logic                           out_valid,
    input  wire logic                           out_ready,
    input  wire logic [scf_pkg::BYTE_W-1:0]     frame_byte,
    input  wire logic                           frame_end,
    input  wire logic [scf_pkg::LEN_W-1:0]      frame_size,
    output int unsigned                         mismatch_count,
    output int unsigned                         beats_due
);
    import scf_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [LEN_W-1:0]  size;
    } frame_beat_t;

    // Shadow of the block's configuration and partial frame.
    logic              short_mode;
    logic [LEN_W-1:0]  short_len;
    logic [LEN_W-1:0]  long_len;
    int unsigned       fill;
    logic [BYTE_W-1:0] partial [MAX_FRAME];

    frame_beat_t frame_beats_q [$];
    int unsigned errs;

    // Feed one received byte into the shadow framer; queue the frame bytes
    // it releases.
    task automatic collect_byte(input logic [BYTE_W-1:0] c);
        int unsigned len;
        frame_beat_t beat;
        len = short_mode ? short_len : long_len;
        if (len < 1)
            len = 1;
        if (len > MAX_FRAME)
            len = MAX_FRAME;
        if (fill >= len)
            fill = 0;
        if (fill == 0)
        begin
            if (c != START_CHAR)
                return;
            partial[0] = c;
            fill = 1;
        end
        else if (c == START_CHAR && (!short_mode || fill + 1 < len))
        begin
            partial[0] = c;
            fill = 1;
        end
        else
        begin
            partial[fill] = c;
            fill++;
        end
        if (fill == len || c == END_CHAR)
        begin
            for (int i = 0; i < fill; i++)
            begin
                beat.data = partial[i];
                beat.last = (i + 1 == fill);
                beat.size = LEN_W'(fill);
                frame_beats_q.push_back(beat);
            end
            fill = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_beat_t want;
        if (!rst_n)
        begin
            short_mode = 1'b0;
            short_len  = SHORT_LEN_RST;
            long_len   = LONG_LEN_RST;
            fill       = 0;
            errs       = 0;
            frame_beats_q.delete();
            mismatch_count <= 0;
            beats_due      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SHORT_MODE:
                    begin
                        short_mode = cfg_data[0];
                        fill = 0;
                    end
                    CFG_SHORT_LEN:
                    begin
                        short_len = cfg_data;
                        fill = 0;
                    end
                    CFG_LONG_LEN:
                    begin
                        long_len = cfg_data;
                        fill = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && in_ready)
                collect_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (frame_beats_q.size() == 0)
                begin
                    if (errs < 10)
                        $display("%0t: unexpected frame beat: byte %02h end %0d size %0d",
                                 $realtime, frame_byte, frame_end, frame_size);
                    errs++;
                end
                else
                begin
                    want = frame_beats_q.pop_front();
                    if (want.data !== frame_byte || want.last !== frame_end ||
                        want.size !== frame_size)
                    begin
                        if (errs < 10)
                        begin
                            $write("%0t: frame beat mismatch: expected byte %02h end %0d",
                                   $realtime, want.data, want.last);
                            $display(" size %0d, got byte %02h end %0d size %0d",
                                     want.size, frame_byte, frame_end, frame_size);
                        end
                        errs++;
                    end
                end
            end
            mismatch_count <= errs;
            beats_due      <= frame_beats_q.size();
        end
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import scf_pkg::*;

    // Cycles to let the front settle after the last owed beat, before a
    // register write or the verdict: a beat is written into the frame store
    // on the clock edge that accepts it, so a handful is plenty.
    localparam int SETTLE_CYCLES = 8;
    // Long receiver hold-off used to fill both frame slots.
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 8;
    localparam int NUM_PHASES    = 8;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SHORT_MODE;
    logic [LEN_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    frame_byte;
    logic                 frame_end;
    logic [LEN_W-1:0]     frame_size;

    int unsigned mismatch_count;
    int unsigned beats_due;

    // Idle mix: percent of cycles the sender sits out / receiver stalls.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   hold_left      = 0;
    // Active frame length as last configured, only used to shape stimulus.
    int   frame_len      = 12;

    always #5 clk = ~clk;

    serial_command_framer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .frame_end  (frame_end),
        .frame_size (frame_size)
    );

    frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_byte     (frame_byte),
        .frame_end      (frame_end),
        .frame_size     (frame_size),
        .mismatch_count (mismatch_count),
        .beats_due      (beats_due)
    );

    // Receiver: stall at random, or hold off entirely for a long stretch
    // once the stimulus asks for it. The hold counter lives here.
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        if (hold_req || hold_left != 0)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one byte, idling first at random. Valid is only dropped when an
    // idle cycle is actually taken, so back-to-back beats keep it high.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_seq(input logic [BYTE_W-1:0] s [$]);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // Any byte except the start and end markers.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        while (b == START_CHAR || b == END_CHAR)
            b = BYTE_W'($urandom);
        return b;
    endfunction

    // Drop valid, drain every owed beat, then let the front settle so a
    // register write cannot race a byte still in flight.
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller drops the write enable after a group.
    task automatic write_reg(input cfg_idx_t idx, input logic [LEN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic mode, input logic [LEN_W-1:0] slen,
                             input logic [LEN_W-1:0] llen);
        write_reg(CFG_SHORT_MODE, LEN_W'(mode));
        write_reg(CFG_SHORT_LEN, slen);
        write_reg(CFG_LONG_LEN, llen);
        cfg_we <= 1'b0;
        frame_len = mode ? slen : llen;
        if (frame_len < 1)
            frame_len = 1;
        if (frame_len > MAX_FRAME)
            frame_len = MAX_FRAME;
    endtask

    initial
    begin
        logic [BYTE_W-1:0] seq [$];
        logic              mode;
        logic [LEN_W-1:0]  slen;
        logic [LEN_W-1:0]  llen;
        int                sent;
        int                kind;
        int                body;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, light idling on both sides, reset configuration.
        send_idle_pct  = 14;
        recv_stall_pct = 14;

        // Leading junk and a leading dash are dropped; dash closes a frame.
        seq = '{8'hFF, END_CHAR, START_CHAR, 8'h00, END_CHAR};
        send_seq(seq);
        // Start marker in mid-frame restarts in long mode.
        seq = '{START_CHAR, 8'hFF, START_CHAR, END_CHAR};
        send_seq(seq);

        // Short mode: a start marker on the final position is kept.
        quiesce();
        configure(1'b1, 5'd3, 5'd12);
        seq = '{START_CHAR, 8'h62, START_CHAR};
        send_seq(seq);

        // Zero length acts as one: a lone start marker is a whole frame.
        quiesce();
        configure(1'b1, 5'd0, 5'd12);
        seq = '{START_CHAR, 8'h62};
        send_seq(seq);

        // Unknown register index must leave the partial frame alone.
        quiesce();
        configure(1'b0, 5'd5, 5'd12);
        seq = '{START_CHAR, 8'h62};
        send_seq(seq);
        quiesce();
        write_reg(CFG_UNUSED, 5'h1F);
        cfg_we <= 1'b0;
        seq = '{8'h63, END_CHAR};
        send_seq(seq);

        // Writing an unused length still discards the partial frame, so the
        // dash that follows is a leading dash and gets dropped.
        seq = '{START_CHAR, 8'h62};
        send_seq(seq);
        quiesce();
        write_reg(CFG_SHORT_LEN, 5'd7);
        cfg_we <= 1'b0;
        seq = '{END_CHAR};
        send_seq(seq);

        // Back-pressure: hold the receiver off while short frames keep
        // coming, so both frame slots fill and the input stalls.
        quiesce();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        seq = '{START_CHAR, END_CHAR, START_CHAR, END_CHAR,
                START_CHAR, END_CHAR, START_CHAR, END_CHAR};
        send_seq(seq);

        // Random phases: each with its own setting and idle mix.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    mode = 1'b0; slen = 5'd5;  llen = 5'd12;
                end
                1:
                begin
                    mode = 1'b1; slen = 5'd16; llen = 5'd1;
                end
                2:
                begin
                    mode = 1'b0; slen = 5'd0;  llen = 5'd31;
                end
                3:
                begin
                    mode = 1'b1; slen = 5'd31; llen = 5'd0;
                end
                4:
                begin
                    mode = 1'b0; slen = 5'd3;  llen = 5'd16;
                end
                5:
                begin
                    mode = 1'b1; slen = 5'd1;  llen = 5'd5;
                end
                default:
                begin
                    mode = 1'($urandom_range(0, 1));
                    slen = LEN_W'($urandom_range(0, 31));
                    llen = LEN_W'($urandom_range(0, 31));
                end
            endcase
            quiesce();
            configure(mode, slen, llen);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 51; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct = 14; recv_stall_pct = 14;
                end
            endcase

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    // Well-formed frame: start, plain body, maybe a dash.
                    send_byte(START_CHAR);
                    sent++;
                    body = $urandom_range(0, frame_len - 1);
                    repeat (body)
                    begin
                        send_byte(plain_byte());
                        sent++;
                    end
                    if (body < frame_len - 1 && $urandom_range(0, 3) != 0)
                    begin
                        send_byte(END_CHAR);
                        sent++;
                    end
                end
                else if (kind < 8)
                begin
                    // Abandoned start: the next start marker lands mid-frame.
                    send_byte(START_CHAR);
                    sent++;
                    repeat ($urandom_range(0, 3))
                    begin
                        send_byte(plain_byte());
                        sent++;
                    end
                end
                else
                begin
                    // Noise: any byte value, markers included.
                    repeat ($urandom_range(1, 4))
                    begin
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                        sent++;
                    end
                end
            end
        end

        quiesce();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && beats_due == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #(2_000_000);
        $display("testbench: errors");
        $finish;
    end

endmodule
